@@ sv/mfra_pkg.sv @@
`default_nettype none

package mfra_pkg;

   // Default depth of the frame store.
   localparam int DEF_MAX_PIXELS = 65536;

   localparam int CHAN_W   = 8;
   localparam int FC_W     = 8;
   localparam int PPF_W    = 17;
   localparam int SUM_W    = 3 * CHAN_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = PPF_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXELS_PER_FRAME = 2'd1;

   localparam logic [FC_W-1:0]  FC_RESET  = 8'd1;
   localparam logic [PPF_W-1:0] PPF_RESET = 17'd65536;

   // Reciprocal of the frame count, ceil(2^RECIP_SHIFT / n).
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_CNT_W = $clog2(RECIP_SHIFT + 1);
   localparam logic [RECIP_W-1:0] RECIP_ONE = 17'h10000;
   localparam int PROD_W = CHAN_W + RECIP_W;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_avg;
      logic [CHAN_W-1:0] green_avg;
      logic [CHAN_W-1:0] blue_avg;
      logic              frame_done;
   } result_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic acc_en;
      logic recip_step;
      logic recip_last;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic fc_write;
      logic out_stall;
   } dp_status_type;

endpackage

`default_nettype wire

@@ sv/mfra_controller.sv @@
`default_nettype none

module mfra_controller
   import mfra_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_ACC   = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [RECIP_CNT_W-1:0] recip_cnt_ff, recip_cnt_in;
   logic                   recip_busy;

   always_comb begin
      recip_busy     = recip_cnt_ff != '0;
      req_ready      = (state_ff == ST_IDLE) && !recip_busy;
      cmd.clear_wr   = state_ff == ST_CLEAR;
      cmd.accept     = req_valid && req_ready;
      cmd.acc_en     = (state_ff == ST_ACC) && !status.out_stall;
      cmd.recip_step = recip_busy && !status.fc_write;
      cmd.recip_last = cmd.recip_step && (recip_cnt_ff == RECIP_CNT_W'(1));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.accept) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (cmd.acc_en) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      recip_cnt_in = recip_cnt_ff;
      if (status.fc_write) begin
         recip_cnt_in = RECIP_CNT_W'(RECIP_SHIFT);
      end else if (recip_busy) begin
         recip_cnt_in = recip_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         recip_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         recip_cnt_ff <= recip_cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/mfra_datapath.sv @@
`default_nettype none

module mfra_datapath
   import mfra_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pixel_type             req_data,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire dp_cmd_type            cmd,
   output dp_status_type              status,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output result_type                 rsp_data
);

   localparam int IDX_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int MAXC_W  = $clog2(MAX_PIXELS + 1);
   localparam int CNT_W   = (PPF_W > MAXC_W) ? PPF_W : MAXC_W;

   // Configuration registers.
   logic [FC_W-1:0]    frame_count_ff;
   logic [PPF_W-1:0]   ppf_ff;
   logic               ppf_write;

   // Reciprocal divider.
   logic [FC_W-1:0]        rem_ff, rem_in;
   logic [RECIP_SHIFT-1:0] quo_ff, quo_in;
   logic [RECIP_W-1:0]     recip_ff;
   logic [FC_W:0]          rem_shift;
   logic [FC_W:0]          rem_diff;
   logic [FC_W-1:0]        n_eff;

   // Position tracking.
   logic [IDX_W-1:0]  pos_ff;
   logic [FC_W-1:0]   frame_pos_ff;
   logic [CNT_W-1:0]  ppf_ext, p_eff, p_last;
   logic              last_frame, last_pixel;

   // Item in flight.
   logic [PROD_W-1:0] prod_r, prod_g, prod_b;
   logic [CHAN_W-1:0] q_r_ff, q_g_ff, q_b_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              first_ff, last_frame_ff, last_pixel_ff;
   logic [SUM_W-1:0]  rd_ff, old_sum, new_sum;

   // Frame store and clearing pass.
   logic [SUM_W-1:0]  store [MAX_PIXELS];
   logic [IDX_W-1:0]  clr_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [SUM_W-1:0]  mem_wd;

   // Output register.
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;

   always_comb begin
      status.fc_write = csr_valid && (csr_index == CSR_FRAME_COUNT);
      ppf_write       = csr_valid && (csr_index == CSR_PIXELS_PER_FRAME);
      status.clear_last = clr_ff == IDX_W'(MAX_PIXELS - 1);
      status.out_stall  = last_frame_ff && rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FC_RESET;
         ppf_ff         <= PPF_RESET;
      end else begin
         if (status.fc_write) begin
            frame_count_ff <= csr_data[FC_W-1:0];
         end
         if (ppf_write) begin
            ppf_ff <= csr_data[PPF_W-1:0];
         end
      end
   end

   // Restoring division of all ones by the frame count, one quotient bit a
   // cycle; the reciprocal is that quotient plus one.
   always_comb begin
      n_eff     = (frame_count_ff == '0) ? FC_W'(1) : frame_count_ff;
      rem_shift = {rem_ff, 1'b1};
      rem_diff  = rem_shift - {1'b0, n_eff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (status.fc_write) begin
         rem_in = '0;
         quo_in = '0;
      end else if (cmd.recip_step) begin
         if (rem_shift >= {1'b0, n_eff}) begin
            rem_in = rem_diff[FC_W-1:0];
            quo_in = {quo_ff[RECIP_SHIFT-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[FC_W-1:0];
            quo_in = {quo_ff[RECIP_SHIFT-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= RECIP_ONE;
      end else if (cmd.recip_last) begin
         recip_ff <= {1'b0, quo_in} + RECIP_W'(1);
      end
   end

   always_comb begin
      ppf_ext = CNT_W'(ppf_ff);
      if (ppf_ff == '0) begin
         p_eff = CNT_W'(1);
      end else if (ppf_ext > CNT_W'(MAX_PIXELS)) begin
         p_eff = CNT_W'(MAX_PIXELS);
      end else begin
         p_eff = ppf_ext;
      end
      p_last     = p_eff - CNT_W'(1);
      last_pixel = CNT_W'(pos_ff) >= p_last;
      last_frame = frame_pos_ff >= (n_eff - FC_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frame_pos_ff <= '0;
      end else if (cmd.accept) begin
         if (last_pixel) begin
            pos_ff <= '0;
            if (last_frame) begin
               frame_pos_ff <= '0;
            end else begin
               frame_pos_ff <= frame_pos_ff + 1'b1;
            end
         end else begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   // Quotient by multiplication with the reciprocal; exact for 8-bit channels.
   always_comb begin
      prod_r = PROD_W'(req_data.red_in)   * PROD_W'(recip_ff);
      prod_g = PROD_W'(req_data.green_in) * PROD_W'(recip_ff);
      prod_b = PROD_W'(req_data.blue_in)  * PROD_W'(recip_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         q_r_ff        <= prod_r[RECIP_SHIFT +: CHAN_W];
         q_g_ff        <= prod_g[RECIP_SHIFT +: CHAN_W];
         q_b_ff        <= prod_b[RECIP_SHIFT +: CHAN_W];
         idx_ff        <= pos_ff;
         first_ff      <= frame_pos_ff == '0;
         last_frame_ff <= last_frame;
         last_pixel_ff <= last_pixel;
      end
   end

   always_comb begin
      old_sum = first_ff ? '0 : rd_ff;
      new_sum = {old_sum[2*CHAN_W +: CHAN_W] + q_r_ff,
                 old_sum[CHAN_W +: CHAN_W]   + q_g_ff,
                 old_sum[0 +: CHAN_W]        + q_b_ff};
      mem_we  = cmd.clear_wr || cmd.acc_en;
      mem_wa  = cmd.clear_wr ? clr_ff : idx_ff;
      mem_wd  = cmd.clear_wr ? '0 : new_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_wa] <= mem_wd;
      end
      if (cmd.accept) begin
         rd_ff <= store[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.acc_en && last_frame_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en && last_frame_ff) begin
         rsp_data_ff.red_avg    <= new_sum[2*CHAN_W +: CHAN_W];
         rsp_data_ff.green_avg  <= new_sum[CHAN_W +: CHAN_W];
         rsp_data_ff.blue_avg   <= new_sum[0 +: CHAN_W];
         rsp_data_ff.frame_done <= last_pixel_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/multi_frame_rgb_average.sv @@
// A result is registered with its quotients and store read, then in the output register.
// A new pixel is taken only after the frame store read and write of the previous one.
// A frame_count write holds off input transfers while the reciprocal is built.
// Reset is synchronous and active high; afterwards the frame store is zeroed one entry per
// cycle, all MAX_PIXELS entries, before the first input transfer. Config writes are always taken.
`default_nettype none

module multi_frame_rgb_average
   import mfra_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pixel_type             req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output result_type                 rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // The controller sequences the clearing pass, the reciprocal divider and
   // the two-step read-modify-write of each pixel. The datapath holds the
   // configuration, positions, frame store and the output register.
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration writes never stall. A frame_count write restarts the
   // reciprocal computation, so back-to-back writes are harmless.
   assign csr_ready = 1'b1;

   mfra_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Each channel is divided by the frame count through a precomputed
   // reciprocal, then summed into the pixel's frame store entry. During the
   // first frame of a run the old entry is ignored, which clears the run.
   mfra_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ sv/mfra_checker.sv @@
`default_nettype none

module mfra_checker
   import mfra_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire result_type            rsp_data,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready,
   input wire logic [CSR_IDX_W-1:0]  csr_index
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The clearing pass keeps input closed right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input open during clearing pass");

   // Each pixel occupies the store for its read and its write.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken during frame store update");

   // A new frame count blocks input until its reciprocal is ready.
   a_recip_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_FRAME_COUNT) |=> !req_ready)
      else $error("input taken while reciprocal is stale");

endmodule

bind multi_frame_rgb_average mfra_checker u_mfra_checker (.*);

`default_nettype wire

@@ tb/multi_frame_rgb_average_tb.sv @@
module multi_frame_rgb_average_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfra_pkg::*;

   // The store is zeroed one entry per cycle after reset, so the limit has to
   // cover that clearing pass as well as the stimulus itself.
   localparam int unsigned CYCLE_LIMIT     = 600000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned DRAIN_CYCLES    = 20;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned MAX_REPORTS     = 10;
   localparam int unsigned RANDOM_PIXELS   = 650;

   // Register indexes that decode to nothing. Writes there must leave the
   // averaging setup alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 2'd3;

   // Tracks the frame store, the raster position and the register values, and
   // keeps the averaged pixels that the block still owes us, oldest first.
   class rgb_average_predictor;
      bit [FC_W-1:0]   frame_count;
      bit [PPF_W-1:0]  pixels_per_frame;
      bit [SUM_W-1:0]  sum_store [DEF_MAX_PIXELS];
      int unsigned     pixel_position;
      bit [FC_W-1:0]   frame_position;
      result_type      expected_pixels [$];
      int unsigned     mismatches;

      function new();
         frame_count      = FC_RESET;
         pixels_per_frame = PPF_RESET;
         pixel_position   = 0;
         frame_position   = 0;
         mismatches       = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_FRAME_COUNT:      frame_count = data[FC_W-1:0];
            CSR_PIXELS_PER_FRAME: pixels_per_frame = data;
            default: ;
         endcase
      endfunction

      function void take_pixel(pixel_type px);
         int unsigned       frames;
         int unsigned       pixels;
         int unsigned       slot;
         bit [CHAN_W-1:0]   red;
         bit [CHAN_W-1:0]   green;
         bit [CHAN_W-1:0]   blue;
         bit [SUM_W-1:0]    prior;
         bit                final_frame;
         bit                final_pixel;
         result_type        res;

         // A zero frame count divides by one; the frame size is at least one
         // pixel and at most the depth of the store.
         frames = (frame_count == 0) ? 1 : frame_count;
         pixels = (pixels_per_frame == 0) ? 1 : pixels_per_frame;
         if (pixels > DEF_MAX_PIXELS)
            pixels = DEF_MAX_PIXELS;
         slot = (pixel_position >= DEF_MAX_PIXELS) ? DEF_MAX_PIXELS - 1 : pixel_position;

         // The first frame of a run overwrites the entry, later frames add to it.
         // Each channel keeps only eight bits of its sum.
         prior = (frame_position != 0) ? sum_store[slot] : '0;
         red   = CHAN_W'(prior[23:16] + px.red_in / frames);
         green = CHAN_W'(prior[15:8] + px.green_in / frames);
         blue  = CHAN_W'(prior[7:0] + px.blue_in / frames);
         sum_store[slot] = {red, green, blue};

         final_frame = frame_position + 1 >= frames;
         final_pixel = pixel_position + 1 >= pixels;
         if (final_frame) begin
            res.red_avg    = red;
            res.green_avg  = green;
            res.blue_avg   = blue;
            res.frame_done = final_pixel;
            expected_pixels.push_back(res);
         end

         if (final_pixel) begin
            pixel_position = 0;
            frame_position = final_frame ? '0 : FC_W'(frame_position + 1);
         end else begin
            pixel_position++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: pixel r=%0d g=%0d b=%0d done=%0b arrived with none expected",
                        got.red_avg, got.green_avg, got.blue_avg, got.frame_done);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.red_avg !== want.red_avg || got.green_avg !== want.green_avg ||
             got.blue_avg !== want.blue_avg || got.frame_done !== want.frame_done) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: expected r=%0d g=%0d b=%0d done=%0b,",
                        want.red_avg, want.green_avg, want.blue_avg, want.frame_done,
                        " got r=%0d g=%0d b=%0d done=%0b",
                        got.red_avg, got.green_avg, got.blue_avg, got.frame_done);
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function bit at_run_start();
         return pixel_position == 0 && frame_position == 0;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   pixel_type             req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   result_type            rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_COUNT;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   rgb_average_predictor  rgb_average = new();

   // Burst flags switch off the random idling on one side for a stretch.
   bit                    req_burst = 1'b0;
   bit                    rsp_burst = 1'b0;
   // Set by the stimulus to make the result side sit out a long stretch.
   bit                    hold_off_request = 1'b0;
   int unsigned           cycle_count = 0;

   multi_frame_rgb_average dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A hung handshake anywhere ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Channel values lean toward the ends of the range; full_pct sets how often
   // a channel is fully lit, which matters when dividing by a large frame count.
   function automatic logic [CHAN_W-1:0] pick_channel(int unsigned full_pct);
      int unsigned       roll;
      logic [CHAN_W-1:0] value;
      roll  = $urandom_range(0, 99);
      value = CHAN_W'($urandom);
      if (roll < full_pct)
         value = '1;
      else if (roll < full_pct + 10)
         value = '0;
      return value;
   endfunction

   function automatic pixel_type random_pixel(int unsigned full_pct);
      pixel_type px;
      px.red_in   = pick_channel(full_pct);
      px.green_in = pick_channel(full_pct);
      px.blue_in  = pick_channel(full_pct);
      return px;
   endfunction

   // Offers one pixel after a random gap and returns at the edge where the
   // transfer took place. Valid stays high after the transfer, so the caller
   // either offers the next pixel right away or lowers it before anything else.
   task automatic send_pixel(input pixel_type px);
      int unsigned gap;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_ready !== 1'b1);
      rgb_average.take_pixel(px);
   endtask

   task automatic send_random_pixels(input int unsigned count, input int unsigned full_pct);
      repeat (count) send_pixel(random_pixel(full_pct));
   endtask

   // Register writes happen only with the block quiet: every owed pixel has been
   // taken, and a settling wait covers a pixel of an early frame that is still
   // in flight and will never produce a transfer.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (rgb_average.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      rgb_average.set_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The frame count write carries random junk above bit 7, which the register
   // has to drop.
   task automatic set_geometry(input int unsigned frames, input int unsigned pixels);
      logic [CSR_DATA_W-1:0] word;
      word = CSR_DATA_W'($urandom);
      word[FC_W-1:0] = frames[FC_W-1:0];
      write_register(CSR_FRAME_COUNT, word);
      write_register(CSR_PIXELS_PER_FRAME, pixels[PPF_W-1:0]);
   endtask

   // A one-frame, one-pixel run closes whatever run was left half done, so the
   // next run starts at the first pixel of its first frame.
   task automatic restart_run();
      set_geometry(1, 1);
      send_pixel(random_pixel(10));
   endtask

   // Result side. Each transfer is preceded by a random stall, except during
   // bursts, and once by the long hold-off that backs the pipeline up.
   initial begin : result_sink
      int unsigned stall;
      int unsigned taken;
      taken = 0;
      forever begin
         if (taken % 40 == 0)
            rsp_burst = ($urandom_range(0, 2) == 0);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else begin
            stall = rsp_burst ? 0 : $urandom_range(0, 15);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         rgb_average.check_result(rsp_data);
         taken++;
      end
   end

   initial begin : stimulus
      int unsigned           fc;
      int unsigned           ppf;
      int unsigned           runs;
      int unsigned           count;
      int unsigned           random_items;
      int unsigned           phase;
      logic [CSR_DATA_W-1:0] stray;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one frame per run, so every pixel comes straight back,
      // and the full frame size, so none of them ends a frame. The first
      // transfer waits out the store clearing pass.
      send_pixel(pixel_type'{8'h00, 8'h00, 8'h00});
      send_pixel(pixel_type'{8'hFF, 8'hFF, 8'hFF});
      send_pixel(pixel_type'{8'h5A, 8'hA5, 8'h3C});

      // A frame size beyond the store depth is clipped to the depth.
      write_register(CSR_PIXELS_PER_FRAME, 17'h1FFFF);
      send_random_pixels(2, 20);

      // Shrinking the frame below the current position ends the frame on the
      // next pixel.
      write_register(CSR_PIXELS_PER_FRAME, 17'd3);
      send_pixel(pixel_type'{8'h01, 8'h80, 8'hFE});

      // A zero frame size behaves as a single pixel: every pixel ends a frame.
      write_register(CSR_PIXELS_PER_FRAME, 17'd0);
      send_random_pixels(2, 20);

      // A zero frame count behaves as one frame.
      set_geometry(0, 2);
      send_pixel(pixel_type'{8'hFF, 8'h00, 8'h7F});
      send_pixel(pixel_type'{8'h00, 8'hFF, 8'h80});

      // Writes to indexes that decode to nothing.
      stray = CSR_DATA_W'($urandom);
      write_register(CSR_UNUSED_LO, stray);
      stray = CSR_DATA_W'($urandom);
      write_register(CSR_UNUSED_HI, stray);
      send_random_pixels(1, 20);

      // Sum wrap: the first frame of a two-frame run stores half values, then
      // the count drops to one, so the run ends and the full values are added
      // on top of the stored halves.
      restart_run();
      set_geometry(2, 1);
      send_pixel(pixel_type'{8'hFF, 8'hFE, 8'hC8});
      write_register(CSR_FRAME_COUNT, 17'd1);
      send_pixel(pixel_type'{8'hFF, 8'hFF, 8'hFF});

      // A clean three-frame run of two pixels, with values that round down.
      set_geometry(3, 2);
      send_pixel(pixel_type'{8'h02, 8'h03, 8'hFF});
      send_pixel(pixel_type'{8'hFE, 8'h01, 8'h00});
      send_pixel(pixel_type'{8'h02, 8'h03, 8'hFF});
      send_pixel(pixel_type'{8'hFE, 8'h01, 8'h00});
      send_pixel(pixel_type'{8'h05, 8'hFF, 8'h04});
      send_pixel(pixel_type'{8'hFF, 8'h02, 8'hFF});

      // Random phases. Most are complete runs with random pixel content; the
      // rest hold long frames, cut runs short, or change the setup mid run.
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_PIXELS) begin
         req_burst = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            // Back-pressure: the sender keeps offering while the result side
            // sits out a long stretch, until the block refuses input.
            if (!rgb_average.at_run_start())
               restart_run();
            set_geometry(1, 16);
            req_burst = 1'b1;
            hold_off_request = 1'b1;
            count = 48;
            send_random_pixels(count, 15);
         end else if (phase == 3) begin
            // Largest frame count: 255 single-pixel frames, where only a full
            // channel survives the division.
            if (!rgb_average.at_run_start())
               restart_run();
            set_geometry(255, 1);
            count = 255;
            send_random_pixels(count, 50);
         end else begin
            case ($urandom_range(0, 9))
               7: begin
                  // Frame sizes at or beyond the store depth; the run is left
                  // open and later phases pick up mid frame.
                  fc = $urandom_range(0, 1);
                  case ($urandom_range(0, 2))
                     0: ppf = DEF_MAX_PIXELS;
                     1: ppf = 17'h1FFFF;
                     default: ppf = $urandom_range(DEF_MAX_PIXELS + 1, 17'h1FFFF);
                  endcase
                  set_geometry(fc, ppf);
                  count = $urandom_range(8, 24);
                  send_random_pixels(count, 15);
               end
               8, 9: begin
                  // Short broken runs with a setup change in the middle.
                  set_geometry($urandom_range(0, 6), $urandom_range(0, 10));
                  count = $urandom_range(1, 12);
                  send_random_pixels(count, 15);
                  set_geometry($urandom_range(0, 6), $urandom_range(0, 10));
                  runs = $urandom_range(1, 12);
                  send_random_pixels(runs, 15);
                  count += runs;
               end
               default: begin
                  // Whole runs back to back.
                  if (!rgb_average.at_run_start())
                     restart_run();
                  fc  = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 12);
                  ppf = $urandom_range(1, 12);
                  runs = (fc * ppf > 60) ? 1 : $urandom_range(1, 3);
                  set_geometry(fc, ppf);
                  count = fc * ppf * runs;
                  send_random_pixels(count, 15);
               end
            endcase
         end
         random_items += count;
         phase++;
      end

      req_valid <= 1'b0;
      req_burst = 1'b0;
      while (rgb_average.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (rgb_average.mismatches == 0 && rgb_average.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
